// File: sv/frcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frcs_pkg;

  localparam int CoordW  = 10;
  localparam int LimitW  = 11;
  localparam int SideW   = 11;
  localparam int ColourW = 16;
  localparam int CountW  = 22;
  localparam int HdrW    = 4;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  // positions in the address header
  localparam logic [HdrW-1:0] HDR_COL_CMD     = 4'd0;
  localparam logic [HdrW-1:0] HDR_COL_LO_MSB  = 4'd1;
  localparam logic [HdrW-1:0] HDR_COL_LO_LSB  = 4'd2;
  localparam logic [HdrW-1:0] HDR_COL_HI_MSB  = 4'd3;
  localparam logic [HdrW-1:0] HDR_COL_HI_LSB  = 4'd4;
  localparam logic [HdrW-1:0] HDR_ROW_CMD     = 4'd5;
  localparam logic [HdrW-1:0] HDR_ROW_LO_MSB  = 4'd6;
  localparam logic [HdrW-1:0] HDR_ROW_LO_LSB  = 4'd7;
  localparam logic [HdrW-1:0] HDR_ROW_HI_MSB  = 4'd8;
  localparam logic [HdrW-1:0] HDR_ROW_HI_LSB  = 4'd9;
  localparam logic [HdrW-1:0] HDR_MEM_CMD     = 4'd10;
  localparam logic [HdrW-1:0] HDR_LEN         = 4'd11;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    logic               is_tick;
    logic               out_of_bounds;
    logic [CoordW-1:0]  col_lo;
    logic [CoordW-1:0]  col_hi;
    logic [CoordW-1:0]  row_lo;
    logic [CoordW-1:0]  row_hi;
    logic [ColourW-1:0] colour;
    logic [SideW-1:0]   width;
    logic [SideW-1:0]   height;
  } frcs_item_t;

endpackage

`default_nettype wire

// File: sv/frcs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module frcs_front
  import frcs_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               opcode,
  input  wire logic [CoordW-1:0]  x_first,
  input  wire logic [CoordW-1:0]  y_first,
  input  wire logic [CoordW-1:0]  x_second,
  input  wire logic [CoordW-1:0]  y_second,
  input  wire logic [ColourW-1:0] fill_rgb565,
  input  wire logic [LimitW-1:0]  panel_width,
  input  wire logic [LimitW-1:0]  panel_height,
  output      logic               push,
  output      frcs_item_t         push_item,
  input  wire logic               queue_full
);

  logic               stage_valid;
  frcs_item_t         stage_item;
  frcs_item_t         item_next;
  logic [LimitW-1:0]  width_lim;
  logic [LimitW-1:0]  height_lim;
  logic               accept;

  always_comb begin
    width_lim  = panel_width;
    height_lim = panel_height;
    if (32'(panel_width) > 32'(MAX_SIDE)) begin
      width_lim = LimitW'(MAX_SIDE);
    end
    if (32'(panel_height) > 32'(MAX_SIDE)) begin
      height_lim = LimitW'(MAX_SIDE);
    end
  end

  always_comb begin
    item_next.is_tick = (opcode == OP_TICK);
    item_next.out_of_bounds = ({1'b0, x_first} >= width_lim) ||
                              ({1'b0, x_second} >= width_lim) ||
                              ({1'b0, y_first} >= height_lim) ||
                              ({1'b0, y_second} >= height_lim);
    item_next.col_lo = (x_first < x_second) ? x_first : x_second;
    item_next.col_hi = (x_first < x_second) ? x_second : x_first;
    item_next.row_lo = (y_first < y_second) ? y_first : y_second;
    item_next.row_hi = (y_first < y_second) ? y_second : y_first;
    item_next.colour = fill_rgb565;
    item_next.width  = {1'b0, item_next.col_hi} - {1'b0, item_next.col_lo} + SideW'(1);
    item_next.height = {1'b0, item_next.row_hi} - {1'b0, item_next.row_lo} + SideW'(1);
  end

  assign in_stall  = stage_valid && queue_full;
  assign accept    = in_valid && !in_stall;
  assign push      = stage_valid && !queue_full;
  assign push_item = stage_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
    if (accept) begin
      stage_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/frcs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module frcs_queue
  import frcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire frcs_item_t push_item,
  output      logic       full,
  output      logic       head_valid,
  output      frcs_item_t head_item,
  input  wire logic       pop
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  frcs_item_t        entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: sv/frcs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module frcs_back
  import frcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire frcs_item_t head_item,
  output      logic       pop,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       byte_valid,
  output      logic [7:0] byte_value,
  output      logic       is_command,
  output      logic       last_byte,
  output      logic       rejected
);

  logic                active;
  logic [HdrW-1:0]     header_index;
  logic [CoordW-1:0]   col_low;
  logic [CoordW-1:0]   col_high;
  logic [CoordW-1:0]   row_low;
  logic [CoordW-1:0]   row_high;
  logic [ColourW-1:0]  held_colour;
  logic [CountW-1:0]   pixel_bytes_left;

  logic [7:0]          hdr_byte;
  logic                hdr_cmd;
  logic [2*SideW-1:0]  area;
  logic [7:0]          pixel_byte;

  assign pop  = head_valid && (!out_valid || !out_stall);
  assign area = head_item.width * head_item.height;
  assign pixel_byte = pixel_bytes_left[0] ? held_colour[7:0] : held_colour[15:8];

  always_comb begin
    hdr_cmd = 1'b0;
    unique case (header_index)
      HDR_COL_CMD: begin
        hdr_byte = CMD_COLUMN_SET;
        hdr_cmd  = 1'b1;
      end
      HDR_COL_LO_MSB: hdr_byte = {6'b0, col_low[9:8]};
      HDR_COL_LO_LSB: hdr_byte = col_low[7:0];
      HDR_COL_HI_MSB: hdr_byte = {6'b0, col_high[9:8]};
      HDR_COL_HI_LSB: hdr_byte = col_high[7:0];
      HDR_ROW_CMD: begin
        hdr_byte = CMD_ROW_SET;
        hdr_cmd  = 1'b1;
      end
      HDR_ROW_LO_MSB: hdr_byte = {6'b0, row_low[9:8]};
      HDR_ROW_LO_LSB: hdr_byte = row_low[7:0];
      HDR_ROW_HI_MSB: hdr_byte = {6'b0, row_high[9:8]};
      HDR_ROW_HI_LSB: hdr_byte = row_high[7:0];
      default: begin
        hdr_byte = CMD_MEMORY_WRITE;
        hdr_cmd  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      header_index     <= '0;
      col_low          <= '0;
      col_high         <= '0;
      row_low          <= '0;
      row_high         <= '0;
      held_colour      <= '0;
      pixel_bytes_left <= '0;
      out_valid        <= 1'b0;
      byte_valid       <= 1'b0;
      byte_value       <= '0;
      is_command       <= 1'b0;
      last_byte        <= 1'b0;
      rejected         <= 1'b0;
    end else if (pop) begin
      out_valid  <= 1'b1;
      byte_valid <= 1'b0;
      byte_value <= '0;
      is_command <= 1'b0;
      last_byte  <= 1'b0;
      rejected   <= 1'b0;
      if (head_item.is_tick) begin
        if (active) begin
          byte_valid <= 1'b1;
          if (header_index < HDR_LEN) begin
            byte_value   <= hdr_byte;
            is_command   <= hdr_cmd;
            header_index <= header_index + HdrW'(1);
          end else begin
            byte_value <= pixel_byte;
            if (pixel_bytes_left <= CountW'(1)) begin
              last_byte        <= 1'b1;
              pixel_bytes_left <= '0;
              active           <= 1'b0;
              header_index     <= '0;
            end else begin
              pixel_bytes_left <= pixel_bytes_left - CountW'(1);
            end
          end
        end
      end else if (active || head_item.out_of_bounds) begin
        rejected <= 1'b1;
      end else begin
        col_low          <= head_item.col_lo;
        col_high         <= head_item.col_hi;
        row_low          <= head_item.row_lo;
        row_high         <= head_item.row_hi;
        held_colour      <= head_item.colour;
        pixel_bytes_left <= {area[CountW-2:0], 1'b0};
        header_index     <= '0;
        active           <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: sv/fill_rectangle_command_stream_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake           payload
// in        in   in_valid/in_stall   opcode, x_first, y_first, x_second, y_second, fill_rgb565
// out       out  out_valid/out_stall byte_valid, byte_value, is_command, last_byte, rejected
// cfg       in   cfg_valid/cfg_ready cfg_index (0 width, 1 height), cfg_data
//
// One result per input transaction, one per cycle sustained while out_stall is low; the path
// runs through the front register, the queue and the output register.
// The front classifies and orders corners; the back holds the fill state and
// computes the pixel byte count with one 11x11 multiply when a start is taken.
// Synchronous reset clears the control state; limits return to 240 x 320.
// out_stall backs up into the two-entry queue; in_stall rises only once it is full.

module fill_rectangle_command_stream_unit
  import frcs_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               opcode,
  input  wire logic [CoordW-1:0]  x_first,
  input  wire logic [CoordW-1:0]  y_first,
  input  wire logic [CoordW-1:0]  x_second,
  input  wire logic [CoordW-1:0]  y_second,
  input  wire logic [ColourW-1:0] fill_rgb565,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic               byte_valid,
  output      logic [7:0]         byte_value,
  output      logic               is_command,
  output      logic               last_byte,
  output      logic               rejected,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [LimitW-1:0]  cfg_data
);

  localparam logic REG_PANEL_WIDTH  = 1'b0;
  localparam logic REG_PANEL_HEIGHT = 1'b1;

  logic [LimitW-1:0] panel_width;
  logic [LimitW-1:0] panel_height;

  logic       push;
  frcs_item_t push_item;
  logic       queue_full;
  logic       head_valid;
  frcs_item_t head_item;
  logic       pop;

  // config is always writable; caller keeps it to idle periods
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= LimitW'(240);
      panel_height <= LimitW'(320);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PANEL_WIDTH:  panel_width  <= cfg_data;
        REG_PANEL_HEIGHT: panel_height <= cfg_data;
        default: ;
      endcase
    end
  end

  frcs_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .x_first     (x_first),
    .y_first     (y_first),
    .x_second    (x_second),
    .y_second    (y_second),
    .fill_rgb565 (fill_rgb565),
    .panel_width (panel_width),
    .panel_height(panel_height),
    .push        (push),
    .push_item   (push_item),
    .queue_full  (queue_full)
  );

  frcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .head_valid(head_valid),
    .head_item (head_item),
    .pop       (pop)
  );

  frcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .byte_valid(byte_valid),
    .byte_value(byte_value),
    .is_command(is_command),
    .last_byte (last_byte),
    .rejected  (rejected)
  );

endmodule

`default_nettype wire
